### rtl/sam_pkg.sv
// Shared types, register codes and reset values for the signal alert monitor.
package sam_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int SLOTS             = 3;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 32;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEED       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_TEMPERATURE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TEMPERATURE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVER_TEMP_LIMIT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_MS      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_TIME      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GEAR        = 3'd6;

    // reset values
    localparam logic [14:0]        RST_MAX_SPEED       = 15'd2500;
    localparam logic signed [15:0] RST_MIN_TEMPERATURE = -16'sd400;
    localparam logic signed [15:0] RST_MAX_TEMPERATURE = 16'sd1500;
    localparam logic signed [15:0] RST_OVER_TEMP_LIMIT = 16'sd1100;
    localparam logic [15:0]        RST_TIMEOUT_MS      = 16'd1000;
    localparam logic [31:0]        RST_START_TIME      = 32'd0;
    localparam logic [7:0]         RST_MAX_GEAR        = 8'd6;

    // alert kinds, one per event slot, in emit order
    localparam logic [1:0] KIND_TIMEOUT  = 2'd0;
    localparam logic [1:0] KIND_ILLEGAL  = 2'd1;
    localparam logic [1:0] KIND_OVERTEMP = 2'd2;

    // severities
    localparam logic [1:0] SEV_INFO     = 2'd0;
    localparam logic [1:0] SEV_WARNING  = 2'd1;
    localparam logic [1:0] SEV_CRITICAL = 2'd2;

    // item commands
    localparam logic CMD_SIGNAL = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [31:0]       timestamp_ms;
        logic signed [15:0] speed;
        logic signed [15:0] temperature;
        logic [7:0]        gear_code;
    } item_t;

    typedef struct packed {
        logic [1:0]  alert_kind;
        logic [1:0]  severity;
        logic        raised;
        logic        speed_bad;
        logic        temperature_bad;
        logic        gear_bad;
        logic [31:0] elapsed_ms;
        logic        last;
    } alert_t;

    typedef struct packed {
        logic [14:0]        max_speed;
        logic signed [15:0] min_temperature;
        logic signed [15:0] max_temperature;
        logic signed [15:0] over_temperature_limit;
        logic [15:0]        timeout_ms;
        logic [31:0]        start_time;
        logic [7:0]         max_gear;
    } cfg_t;

    // evaluator to event buffer
    typedef struct packed {
        logic             load;
        logic [SLOTS-1:0] mask;
    } ev_load_t;

endpackage

### rtl/sam_cfg_regs.sv
// Configuration register file of the signal alert monitor.
module sam_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sam_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sam_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output sam_pkg::cfg_t                       cfg
);

    sam_pkg::cfg_t cfg_reg;
    sam_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sam_pkg::REG_MAX_SPEED:       cfg_next.max_speed = cfg_data[14:0];
                sam_pkg::REG_MIN_TEMPERATURE: cfg_next.min_temperature = cfg_data[15:0];
                sam_pkg::REG_MAX_TEMPERATURE: cfg_next.max_temperature = cfg_data[15:0];
                sam_pkg::REG_OVER_TEMP_LIMIT:
                    cfg_next.over_temperature_limit = cfg_data[15:0];
                sam_pkg::REG_TIMEOUT_MS:      cfg_next.timeout_ms = cfg_data[15:0];
                sam_pkg::REG_START_TIME:      cfg_next.start_time = cfg_data[31:0];
                sam_pkg::REG_MAX_GEAR:        cfg_next.max_gear = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed              <= sam_pkg::RST_MAX_SPEED;
            cfg_reg.min_temperature        <= sam_pkg::RST_MIN_TEMPERATURE;
            cfg_reg.max_temperature        <= sam_pkg::RST_MAX_TEMPERATURE;
            cfg_reg.over_temperature_limit <= sam_pkg::RST_OVER_TEMP_LIMIT;
            cfg_reg.timeout_ms             <= sam_pkg::RST_TIMEOUT_MS;
            cfg_reg.start_time             <= sam_pkg::RST_START_TIME;
            cfg_reg.max_gear               <= sam_pkg::RST_MAX_GEAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/sam_eval.sv
// Input register, alert flag state and per-item event evaluation.
module sam_eval
#(
    parameter int TIME_BITS = sam_pkg::TIME_BITS_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sam_pkg::cfg_t                         cfg,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  sam_pkg::item_t                        item,
    input  logic                                  buf_free,
    output sam_pkg::ev_load_t                     ev_load,
    output sam_pkg::alert_t [sam_pkg::SLOTS-1:0]  ev_slots
);

    // times compare modulo 2^min(TIME_BITS, 32); the port fields carry 32 bits
    localparam int CMP_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

    sam_pkg::item_t item_reg;
    logic           item_valid_reg;
    logic           item_valid_next;

    logic                timeout_active_reg, timeout_active_next;
    logic                illegal_active_reg, illegal_active_next;
    logic                overtemp_active_reg, overtemp_active_next;
    logic                seen_signal_reg, seen_signal_next;
    logic [CMP_BITS-1:0] last_signal_time_reg, last_signal_time_next;

    logic                eval_take;
    logic                take_in;
    logic [CMP_BITS-1:0] now;
    logic [CMP_BITS-1:0] ref_time;
    logic [CMP_BITS-1:0] elapsed;
    logic                tmo_hit;
    logic                sb, tb, gb, illegal, over;
    logic [sam_pkg::SLOTS-1:0] mask;

    assign eval_take  = item_valid_reg && buf_free;
    assign item_stall = item_valid_reg && !buf_free;
    assign take_in    = item_valid && !item_stall;

    always_comb
    begin
        if (take_in)
            item_valid_next = 1'b1;
        else if (eval_take)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_comb
    begin
        now      = item_reg.timestamp_ms[CMP_BITS-1:0];
        ref_time = seen_signal_reg ? last_signal_time_reg : cfg.start_time[CMP_BITS-1:0];
        elapsed  = now - ref_time;
        // negative elapsed time never times out
        tmo_hit = (now >= ref_time) && (elapsed >= CMP_BITS'(cfg.timeout_ms));

        sb = item_reg.speed[15] || (item_reg.speed[14:0] > cfg.max_speed);
        tb = (item_reg.temperature < cfg.min_temperature) ||
             (item_reg.temperature > cfg.max_temperature);
        gb = item_reg.gear_code > cfg.max_gear;
        illegal = sb || tb || gb;
        over    = !tb && (item_reg.temperature > cfg.over_temperature_limit);
    end

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < sam_pkg::SLOTS; i++)
        begin
            ev_slots[i] = '0;
        end
        ev_slots[0].alert_kind = sam_pkg::KIND_TIMEOUT;
        ev_slots[1].alert_kind = sam_pkg::KIND_ILLEGAL;
        ev_slots[2].alert_kind = sam_pkg::KIND_OVERTEMP;

        timeout_active_next   = timeout_active_reg;
        illegal_active_next   = illegal_active_reg;
        overtemp_active_next  = overtemp_active_reg;
        seen_signal_next      = seen_signal_reg;
        last_signal_time_next = last_signal_time_reg;

        if (item_reg.cmd == sam_pkg::CMD_TICK)
        begin
            if (tmo_hit != timeout_active_reg)
            begin
                mask[0]             = 1'b1;
                timeout_active_next = tmo_hit;
                if (tmo_hit)
                begin
                    ev_slots[0].severity   = sam_pkg::SEV_CRITICAL;
                    ev_slots[0].raised     = 1'b1;
                    ev_slots[0].elapsed_ms = 32'(elapsed);
                end
            end
        end
        else
        begin
            seen_signal_next      = 1'b1;
            last_signal_time_next = now;
            if (timeout_active_reg)
            begin
                mask[0]             = 1'b1;
                timeout_active_next = 1'b0;
            end
            if (illegal != illegal_active_reg)
            begin
                mask[1]             = 1'b1;
                illegal_active_next = illegal;
                if (illegal)
                begin
                    ev_slots[1].severity        = sam_pkg::SEV_WARNING;
                    ev_slots[1].raised          = 1'b1;
                    ev_slots[1].speed_bad       = sb;
                    ev_slots[1].temperature_bad = tb;
                    ev_slots[1].gear_bad        = gb;
                end
            end
            if (over != overtemp_active_reg)
            begin
                mask[2]              = 1'b1;
                overtemp_active_next = over;
                if (over)
                begin
                    ev_slots[2].severity = sam_pkg::SEV_CRITICAL;
                    ev_slots[2].raised   = 1'b1;
                end
            end
        end
    end

    assign ev_load.load = eval_take;
    assign ev_load.mask = mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg       <= 1'b0;
            timeout_active_reg   <= 1'b0;
            illegal_active_reg   <= 1'b0;
            overtemp_active_reg  <= 1'b0;
            seen_signal_reg      <= 1'b0;
            last_signal_time_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (eval_take)
            begin
                timeout_active_reg   <= timeout_active_next;
                illegal_active_reg   <= illegal_active_next;
                overtemp_active_reg  <= overtemp_active_next;
                seen_signal_reg      <= seen_signal_next;
                last_signal_time_reg <= last_signal_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            item_reg <= item;
    end

endmodule

### rtl/sam_event_buf.sv
// Event slot buffer and output register: drains one alert beat per cycle in kind order while alert_stall is low.
module sam_event_buf
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sam_pkg::ev_load_t                     ev_load,
    input  sam_pkg::alert_t [sam_pkg::SLOTS-1:0]  ev_slots,
    output logic                                  buf_free,
    output logic                                  alert_valid,
    input  logic                                  alert_stall,
    output sam_pkg::alert_t                       alert
);

    sam_pkg::alert_t [sam_pkg::SLOTS-1:0] slot_reg;
    logic [sam_pkg::SLOTS-1:0]            mask_reg, mask_next;
    logic [sam_pkg::SLOTS-1:0]            mask_after;
    logic [sam_pkg::SLOTS-1:0]            sel_oh;
    logic [1:0]                           sel_idx;
    logic                                 alert_valid_reg, alert_valid_next;
    sam_pkg::alert_t                      alert_reg, alert_next;
    logic                                 out_take, out_open, move;

    assign out_take = alert_valid_reg && !alert_stall;
    assign out_open = !alert_valid_reg || out_take;

    always_comb
    begin
        sel_oh  = '0;
        sel_idx = 2'd0;
        priority if (mask_reg[0])
        begin
            sel_oh  = 3'b001;
            sel_idx = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel_oh  = 3'b010;
            sel_idx = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel_oh  = 3'b100;
            sel_idx = 2'd2;
        end
        else
        begin
            sel_oh  = '0;
            sel_idx = 2'd0;
        end
    end

    assign move       = out_open && (mask_reg != '0);
    assign mask_after = move ? (mask_reg & ~sel_oh) : mask_reg;
    assign buf_free   = (mask_after == '0);
    assign mask_next  = ev_load.load ? ev_load.mask : mask_after;

    always_comb
    begin
        alert_next = alert_reg;
        if (move)
        begin
            alert_next      = slot_reg[sel_idx];
            // final beat of the item when nothing else is left in the slots
            alert_next.last = (mask_after == '0);
        end
        if (move)
            alert_valid_next = 1'b1;
        else if (out_take)
            alert_valid_next = 1'b0;
        else
            alert_valid_next = alert_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg        <= '0;
            alert_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg        <= mask_next;
            alert_valid_reg <= alert_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alert_reg <= alert_next;
        if (ev_load.load)
            slot_reg <= ev_slots;
    end

    assign alert_valid = alert_valid_reg;
    assign alert       = alert_reg;

endmodule

### rtl/signal_alert_monitor.sv
// Top level of the signal alert monitor.
// An item is registered on acceptance and evaluated from that register, once the
// event buffer is free, against the alert flags and configuration; its events (zero
// to three, in kind order timeout, illegal, over-temperature) go into a three-slot
// buffer and leave through an output register one beat per cycle while alert_stall
// is low, the final one marked by last. An item reaches its first alert beat through
// the input, slot and output registers. The single drain port of the event buffer
// paces items: the next item is evaluated only once the buffer has moved out the
// last event of the previous one. Configuration writes take effect on the next cycle.
module signal_alert_monitor
#(
    parameter int TIME_BITS = sam_pkg::TIME_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  sam_pkg::item_t                    item,
    output logic                              alert_valid,
    input  logic                              alert_stall,
    output sam_pkg::alert_t                   alert,
    input  logic                              cfg_we,
    input  logic [sam_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sam_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    sam_pkg::cfg_t                        cfg;
    sam_pkg::ev_load_t                    ev_load;
    sam_pkg::alert_t [sam_pkg::SLOTS-1:0] ev_slots;
    logic                                 buf_free;

    sam_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sam_eval
    #(
        .TIME_BITS (TIME_BITS)
    )
    u_eval
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .buf_free   (buf_free),
        .ev_load    (ev_load),
        .ev_slots   (ev_slots)
    );

    sam_event_buf u_event_buf
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_load     (ev_load),
        .ev_slots    (ev_slots),
        .buf_free    (buf_free),
        .alert_valid (alert_valid),
        .alert_stall (alert_stall),
        .alert       (alert)
    );

endmodule
